FILE: design/bbm_pkg.sv
`default_nettype none

package bbm_pkg;

   // Width of one coordinate at the block's ports.
   localparam int COORD_W = 32;
   // Width of a vector component on its way into the normaliser.
   localparam int VEC_W = 64;
   // After scaling, the largest component magnitude has its leading one here.
   localparam int NORM_MSB = 29;
   // Magnitude bits of a scaled component.
   localparam int MAG_W = 30;
   // Signed width of a shrunk component.
   localparam int SHR_W = 31;
   // Sum of three squared scaled components.
   localparam int SUM_W = 62;
   // Bits of the integer square root of that sum.
   localparam int ROOT_W = 31;
   // Remainder width inside the square root stages.
   localparam int REM_W = 34;
   // Position field of a 64-bit leading-one search.
   localparam int POS_W = 6;

   typedef enum logic [1:0] {
      MODE_SPHERE = 2'd0,
      MODE_UP     = 2'd1,
      MODE_RIGHT  = 2'd2,
      MODE_BAD    = 2'd3
   } mode_type;

   // What travels with a request alongside the first normalisation.
   typedef struct packed {
      mode_type                      mode;
      logic [2:0][COORD_W-1:0]       ax;
      logic [2:0][SHR_W-1:0]         as;
   } tag_type;

   typedef struct packed {
      logic                          ok;
      logic [2:0][COORD_W-1:0]       right;
      logic [2:0][COORD_W-1:0]       up;
      logic [2:0][COORD_W-1:0]       look;
   } rsp_type;

   // Position of the leading one of a 64-bit word, zero for a zero word.
   function automatic logic [POS_W-1:0] msb_pos(input logic [VEC_W-1:0] v);
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 0; i < VEC_W; i++) begin
         if (v[i]) p = POS_W'(i);
      end
      return p;
   endfunction

   // Clamp a signed 64-bit value to the signed 32-bit range.
   function automatic logic [COORD_W-1:0] sat32(input logic signed [VEC_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v > 64'sh7FFF_FFFF) r = 32'h7FFF_FFFF;
      else if (v < -64'sh8000_0000) r = 32'h8000_0000;
      else r = v[COORD_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/bbm_if.sv
`default_nettype none

interface bbm_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic signed [31:0]  eye_x;
   logic signed [31:0]  eye_y;
   logic signed [31:0]  eye_z;
   logic signed [31:0]  obj_x;
   logic signed [31:0]  obj_y;
   logic signed [31:0]  obj_z;
   logic signed [31:0]  axis_x;
   logic signed [31:0]  axis_y;
   logic signed [31:0]  axis_z;

   modport source (output valid, mode, eye_x, eye_y, eye_z, obj_x, obj_y, obj_z,
                   axis_x, axis_y, axis_z, input ready);
   modport sink (input valid, mode, eye_x, eye_y, eye_z, obj_x, obj_y, obj_z,
                 axis_x, axis_y, axis_z, output ready);
endinterface

interface bbm_rsp_if;
   logic                valid;
   logic                ready;
   logic                ok;
   logic signed [31:0]  right_x;
   logic signed [31:0]  right_y;
   logic signed [31:0]  right_z;
   logic signed [31:0]  up_x;
   logic signed [31:0]  up_y;
   logic signed [31:0]  up_z;
   logic signed [31:0]  look_x;
   logic signed [31:0]  look_y;
   logic signed [31:0]  look_z;

   modport source (output valid, ok, right_x, right_y, right_z, up_x, up_y, up_z,
                   look_x, look_y, look_z, input ready);
   modport sink (input valid, ok, right_x, right_y, right_z, up_x, up_y, up_z,
                 look_x, look_y, look_z, output ready);
endinterface

`default_nettype wire

FILE: design/bbm_prep.sv
`default_nettype none

// Look vector, pre-shrink of look and axis, and the first cross product.
module bbm_prep (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   in_valid,
   input  bbm_pkg::mode_type                      in_mode,
   input  logic [2:0][bbm_pkg::COORD_W-1:0]       in_eye,
   input  logic [2:0][bbm_pkg::COORD_W-1:0]       in_obj,
   input  logic [2:0][bbm_pkg::COORD_W-1:0]       in_axis,
   output logic                                   out_valid,
   output logic [2:0][bbm_pkg::VEC_W-1:0]         out_vec,
   output bbm_pkg::tag_type                       out_tag
);

   localparam int CW = bbm_pkg::COORD_W;
   localparam int DW = CW + 1;
   localparam int SW = bbm_pkg::SHR_W;
   localparam int PW = 2 * SW;
   localparam int VW = bbm_pkg::VEC_W;
   localparam int NS = 6;

   logic [NS-1:0]          vld_ff;
   bbm_pkg::mode_type      mode_ff [NS];
   logic [2:0][CW-1:0]     ax_ff [NS];
   logic [2:0][DW-1:0]     d_ff [NS-1];

   logic [2:0][DW-1:0]     d1_in;
   logic [2:0][CW-1:0]     amag2_in, amag2_ff, amag3_ff;
   logic [2:0][DW-1:0]     dmag2_in, dmag2_ff, dmag3_ff;
   logic [2:0]             asgn2_ff, asgn3_ff, dsgn2_ff, dsgn3_ff;
   logic [bbm_pkg::POS_W-1:0] apos, dpos, ash3_in, ash3_ff, dsh3_in, dsh3_ff;
   logic [2:0][SW-1:0]     as4_in, as4_ff, as5_ff, ds4_in, ds4_ff;
   logic signed [PW-1:0]   pr5_in [6];
   logic signed [PW-1:0]   pr5_ff [6];
   logic signed [VW-1:0]   c_in [3];
   logic [2:0][VW-1:0]     vec6_in, vec6_ff;
   logic [2:0][SW-1:0]     as6_ff;

   always_comb begin
      logic [CW-1:0] sa;
      logic [DW-1:0] sd;
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = {in_eye[i][CW-1], in_eye[i]} - {in_obj[i][CW-1], in_obj[i]};
         amag2_in[i] = ax_ff[0][i][CW-1] ? -ax_ff[0][i] : ax_ff[0][i];
         dmag2_in[i] = d_ff[0][i][DW-1] ? -d_ff[0][i] : d_ff[0][i];
      end
      apos = bbm_pkg::msb_pos(VW'(amag2_ff[0] | amag2_ff[1] | amag2_ff[2]));
      dpos = bbm_pkg::msb_pos(VW'(dmag2_ff[0] | dmag2_ff[1] | dmag2_ff[2]));
      ash3_in = (apos > bbm_pkg::POS_W'(bbm_pkg::NORM_MSB)) ?
                apos - bbm_pkg::POS_W'(bbm_pkg::NORM_MSB) : '0;
      dsh3_in = (dpos > bbm_pkg::POS_W'(bbm_pkg::NORM_MSB)) ?
                dpos - bbm_pkg::POS_W'(bbm_pkg::NORM_MSB) : '0;
      for (int i = 0; i < 3; i++) begin
         sa = amag3_ff[i] >> ash3_ff;
         sd = dmag3_ff[i] >> dsh3_ff;
         as4_in[i] = asgn3_ff[i] ? -{1'b0, sa[SW-2:0]} : {1'b0, sa[SW-2:0]};
         ds4_in[i] = dsgn3_ff[i] ? -{1'b0, sd[SW-2:0]} : {1'b0, sd[SW-2:0]};
      end
      // Cross product of shrunk axis and shrunk look.
      pr5_in[0] = $signed(as4_ff[1]) * $signed(ds4_ff[2]);
      pr5_in[1] = $signed(as4_ff[2]) * $signed(ds4_ff[1]);
      pr5_in[2] = $signed(as4_ff[2]) * $signed(ds4_ff[0]);
      pr5_in[3] = $signed(as4_ff[0]) * $signed(ds4_ff[2]);
      pr5_in[4] = $signed(as4_ff[0]) * $signed(ds4_ff[1]);
      pr5_in[5] = $signed(as4_ff[1]) * $signed(ds4_ff[0]);
      for (int i = 0; i < 3; i++) begin
         c_in[i] = VW'(pr5_ff[2*i]) - VW'(pr5_ff[2*i+1]);
      end
      for (int i = 0; i < 3; i++) begin
         case (mode_ff[4])
            bbm_pkg::MODE_SPHERE: vec6_in[i] = VW'($signed(d_ff[4][i]));
            bbm_pkg::MODE_RIGHT:  vec6_in[i] = -c_in[i];
            default:              vec6_in[i] = c_in[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode_ff[0] <= in_mode;
         ax_ff[0]   <= in_axis;
         d_ff[0]    <= d1_in;
         for (int s = 1; s < NS; s++) begin
            mode_ff[s] <= mode_ff[s-1];
            ax_ff[s]   <= ax_ff[s-1];
         end
         for (int s = 1; s < NS - 1; s++) begin
            d_ff[s] <= d_ff[s-1];
         end
         amag2_ff <= amag2_in;
         dmag2_ff <= dmag2_in;
         for (int i = 0; i < 3; i++) begin
            asgn2_ff[i] <= ax_ff[0][i][CW-1];
            dsgn2_ff[i] <= d_ff[0][i][DW-1];
         end
         amag3_ff <= amag2_ff;
         dmag3_ff <= dmag2_ff;
         asgn3_ff <= asgn2_ff;
         dsgn3_ff <= dsgn2_ff;
         ash3_ff  <= ash3_in;
         dsh3_ff  <= dsh3_in;
         as4_ff   <= as4_in;
         ds4_ff   <= ds4_in;
         as5_ff   <= as4_ff;
         pr5_ff   <= pr5_in;
         as6_ff   <= as5_ff;
         vec6_ff  <= vec6_in;
      end
   end

   assign out_valid    = vld_ff[NS-1];
   assign out_vec      = vec6_ff;
   assign out_tag.mode = mode_ff[NS-1];
   assign out_tag.ax   = ax_ff[NS-1];
   assign out_tag.as   = as6_ff;

endmodule

`default_nettype wire

FILE: design/bbm_norm.sv
`default_nettype none

// Pipelined vector normaliser: scale, sum of squares, square root one
// digit per stage, then three restoring dividers one quotient bit per stage.
module bbm_norm #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic [2:0][bbm_pkg::VEC_W-1:0]        in_vec,
   input  logic [SIDE_W-1:0]                     in_side,
   output logic                                  out_valid,
   output logic                                  out_ok,
   output logic [2:0][FRAC_BITS+1:0]             out_vec,
   output logic [SIDE_W-1:0]                     out_side
);

   localparam int OW  = FRAC_BITS + 2;
   localparam int QB  = FRAC_BITS + 1;
   localparam int VW  = bbm_pkg::VEC_W;
   localparam int MW  = bbm_pkg::MAG_W;
   localparam int SW  = bbm_pkg::SUM_W;
   localparam int RT  = bbm_pkg::ROOT_W;
   localparam int RW  = bbm_pkg::REM_W;
   localparam int PW  = bbm_pkg::POS_W;
   localparam int DW  = RT + 1;
   localparam int LAT = 5 + RT + QB + 1;

   logic [LAT-1:0]         vld_ff;
   logic [SIDE_W-1:0]      side_ff [LAT];
   logic [2:0]             sgn_ff [LAT-1];

   logic [2:0][VW-1:0]     mag1_in, mag1_ff, mag2_ff;
   logic [VW-1:0]          mag_or;
   logic [PW-1:0]          pos2_ff;
   logic                   zero2_ff, zero3_ff, zero4_ff, zero5_ff;
   logic [2:0][MW-1:0]     t3_in, t3_ff, t4_ff, t5_ff;
   logic [2:0][2*MW-1:0]   sq4_in, sq4_ff;
   logic [SW-1:0]          sum5_in, sum5_ff;

   logic [SW-1:0]          sx_ff [RT];
   logic [RW-1:0]          srem_in [RT];
   logic [RW-1:0]          srem_ff [RT];
   logic [RT-1:0]          sroot_in [RT];
   logic [RT-1:0]          sroot_ff [RT];
   logic [2:0][MW-1:0]     st_ff [RT];
   logic                   sz_ff [RT];

   logic [2:0][DW-1:0]     dr_in [QB];
   logic [2:0][DW-1:0]     dr_ff [QB];
   logic [2:0][QB-1:0]     dq_in [QB];
   logic [2:0][QB-1:0]     dq_ff [QB];
   logic [RT-1:0]          dl_ff [QB];
   logic                   dz_ff [QB];

   logic [2:0][OW-1:0]     res_in, res_ff;
   logic                   ok_ff;

   always_comb begin
      logic [VW-1:0] sh;
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = in_vec[i][VW-1] ? -in_vec[i] : in_vec[i];
      end
      mag_or = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      // Bring the largest magnitude to a leading one at NORM_MSB; a right
      // shift of the magnitude truncates towards zero.
      for (int i = 0; i < 3; i++) begin
         if (pos2_ff > PW'(bbm_pkg::NORM_MSB)) begin
            sh = mag2_ff[i] >> (pos2_ff - PW'(bbm_pkg::NORM_MSB));
         end else begin
            sh = mag2_ff[i] << (PW'(bbm_pkg::NORM_MSB) - pos2_ff);
         end
         t3_in[i]  = sh[MW-1:0];
         sq4_in[i] = t3_ff[i] * t3_ff[i];
      end
      sum5_in = SW'(sq4_ff[0]) + SW'(sq4_ff[1]) + SW'(sq4_ff[2]);
   end

   // Square root, two radicand bits per stage.
   always_comb begin
      logic [SW-1:0] xp;
      logic [RW-1:0] remp;
      logic [RT-1:0] rootp;
      logic [RW-1:0] rem_sh;
      logic [RW-1:0] trial;
      for (int j = 0; j < RT; j++) begin
         if (j == 0) begin
            xp    = sum5_ff;
            remp  = '0;
            rootp = '0;
         end else begin
            xp    = sx_ff[j-1];
            remp  = srem_ff[j-1];
            rootp = sroot_ff[j-1];
         end
         rem_sh = {remp[RW-3:0], xp[2*(RT-1-j) +: 2]};
         trial  = {{(RW-RT-2){1'b0}}, rootp, 2'b01};
         if (rem_sh >= trial) begin
            srem_in[j]  = rem_sh - trial;
            sroot_in[j] = {rootp[RT-2:0], 1'b1};
         end else begin
            srem_in[j]  = rem_sh;
            sroot_in[j] = {rootp[RT-2:0], 1'b0};
         end
      end
   end

   // Restoring division of (t << FRAC_BITS) by the length, one bit per stage.
   always_comb begin
      logic [DW-1:0] rin;
      logic [QB-1:0] qp;
      logic [RT-1:0] len;
      for (int k = 0; k < QB; k++) begin
         for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
               rin = DW'(st_ff[RT-1][i]);
               qp  = '0;
               len = sroot_ff[RT-1];
            end else begin
               rin = {dr_ff[k-1][i][DW-2:0], 1'b0};
               qp  = dq_ff[k-1][i];
               len = dl_ff[k-1];
            end
            if (rin >= {1'b0, len}) begin
               dr_in[k][i] = rin - {1'b0, len};
               dq_in[k][i] = {qp[QB-2:0], 1'b1};
            end else begin
               dr_in[k][i] = rin;
               dq_in[k][i] = {qp[QB-2:0], 1'b0};
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         res_in[i] = sgn_ff[LAT-2][i] ? -{1'b0, dq_ff[QB-1][i]} : {1'b0, dq_ff[QB-1][i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         sgn_ff[0]  <= {in_vec[2][VW-1], in_vec[1][VW-1], in_vec[0][VW-1]};
         for (int s = 1; s < LAT; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 1; s < LAT - 1; s++) begin
            sgn_ff[s] <= sgn_ff[s-1];
         end
         mag1_ff  <= mag1_in;
         mag2_ff  <= mag1_ff;
         pos2_ff  <= bbm_pkg::msb_pos(mag_or);
         zero2_ff <= (mag_or == '0);
         t3_ff    <= t3_in;
         zero3_ff <= zero2_ff;
         sq4_ff   <= sq4_in;
         t4_ff    <= t3_ff;
         zero4_ff <= zero3_ff;
         sum5_ff  <= sum5_in;
         t5_ff    <= t4_ff;
         zero5_ff <= zero4_ff;
         for (int j = 0; j < RT; j++) begin
            sx_ff[j]    <= (j == 0) ? sum5_ff : sx_ff[j-1];
            st_ff[j]    <= (j == 0) ? t5_ff : st_ff[j-1];
            sz_ff[j]    <= (j == 0) ? zero5_ff : sz_ff[j-1];
            srem_ff[j]  <= srem_in[j];
            sroot_ff[j] <= sroot_in[j];
         end
         for (int k = 0; k < QB; k++) begin
            dr_ff[k] <= dr_in[k];
            dq_ff[k] <= dq_in[k];
            dl_ff[k] <= (k == 0) ? sroot_ff[RT-1] : dl_ff[k-1];
            dz_ff[k] <= (k == 0) ? sz_ff[RT-1] : dz_ff[k-1];
         end
         res_ff <= res_in;
         ok_ff  <= ~dz_ff[QB-1];
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_side  = side_ff[LAT-1];
   assign out_vec   = res_ff;
   assign out_ok    = ok_ff;

endmodule

`default_nettype wire

FILE: design/bbm_mid.sv
`default_nettype none

// Builds the vector for the second normalisation from the first result.
module bbm_mid #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic                                  in_ok,
   input  logic [2:0][FRAC_BITS+1:0]             in_n,
   input  bbm_pkg::tag_type                      in_tag,
   output logic                                  out_valid,
   output logic [2:0][bbm_pkg::VEC_W-1:0]        out_vec,
   output bbm_pkg::tag_type                      out_tag,
   output logic [2:0][FRAC_BITS+1:0]             out_n,
   output logic                                  out_ok
);

   localparam int OW = FRAC_BITS + 2;
   localparam int SW = bbm_pkg::SHR_W;
   localparam int PW = SW + OW;
   localparam int VW = bbm_pkg::VEC_W;
   localparam logic signed [VW-1:0] ONE_SQ = VW'(1) << (2 * FRAC_BITS);

   logic [1:0]              vld_ff;
   bbm_pkg::tag_type        tag_ff [2];
   logic [2:0][OW-1:0]      n_ff [2];
   logic [1:0]              ok_ff;
   logic signed [PW-1:0]    pr_in [9];
   logic signed [PW-1:0]    pr_ff [9];
   logic signed [VW-1:0]    c_in [3];
   logic [2:0][VW-1:0]      vec_in, vec_ff;

   always_comb begin
      // Products of the shrunk axis and n for the restricted modes.
      pr_in[0] = $signed(in_tag.as[1]) * $signed(in_n[2]);
      pr_in[1] = $signed(in_tag.as[2]) * $signed(in_n[1]);
      pr_in[2] = $signed(in_tag.as[2]) * $signed(in_n[0]);
      pr_in[3] = $signed(in_tag.as[0]) * $signed(in_n[2]);
      pr_in[4] = $signed(in_tag.as[0]) * $signed(in_n[1]);
      pr_in[5] = $signed(in_tag.as[1]) * $signed(in_n[0]);
      // View y times each view component for the spherical up vector.
      pr_in[6] = $signed(in_n[1]) * $signed(in_n[0]);
      pr_in[7] = $signed(in_n[1]) * $signed(in_n[1]);
      pr_in[8] = $signed(in_n[1]) * $signed(in_n[2]);
      for (int i = 0; i < 3; i++) begin
         c_in[i] = VW'(pr_ff[2*i]) - VW'(pr_ff[2*i+1]);
      end
      case (tag_ff[0].mode)
         bbm_pkg::MODE_SPHERE: begin
            vec_in[0] = -VW'(pr_ff[6]);
            vec_in[1] = ONE_SQ - VW'(pr_ff[7]);
            vec_in[2] = -VW'(pr_ff[8]);
         end
         bbm_pkg::MODE_RIGHT: begin
            for (int i = 0; i < 3; i++) vec_in[i] = -c_in[i];
         end
         default: begin
            for (int i = 0; i < 3; i++) vec_in[i] = c_in[i];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= in_tag;
         tag_ff[1] <= tag_ff[0];
         n_ff[0]   <= in_n;
         n_ff[1]   <= n_ff[0];
         ok_ff     <= {ok_ff[0], in_ok};
         pr_ff     <= pr_in;
         vec_ff    <= vec_in;
      end
   end

   assign out_valid = vld_ff[1];
   assign out_vec   = vec_ff;
   assign out_tag   = tag_ff[1];
   assign out_n     = n_ff[1];
   assign out_ok    = ok_ff[1];

endmodule

`default_nettype wire

FILE: design/bbm_post.sv
`default_nettype none

// Spherical right vector, row selection per mode, and the result register.
module bbm_post #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic                                  in_ok1,
   input  logic [2:0][FRAC_BITS+1:0]             in_n1,
   input  logic                                  in_ok2,
   input  logic [2:0][FRAC_BITS+1:0]             in_n2,
   input  bbm_pkg::tag_type                      in_tag,
   output logic                                  out_valid,
   output bbm_pkg::rsp_type                      out_rsp
);

   localparam int OW = FRAC_BITS + 2;
   localparam int PW = 2 * OW;
   localparam int VW = bbm_pkg::VEC_W;

   logic                    vld1_ff, vld2_ff;
   logic                    ok1_ff, ok2_ff;
   logic [2:0][OW-1:0]      n1_ff, n2_ff;
   bbm_pkg::tag_type        tag_ff;
   logic signed [PW-1:0]    pr_in [6];
   logic signed [PW-1:0]    pr_ff [6];
   logic [2:0][VW-1:0]      rgt, up, lk;
   bbm_pkg::rsp_type        rsp_in, rsp_ff;

   always_comb begin
      logic signed [VW-1:0] c;
      logic [VW-1:0]        m;
      logic                 good;
      // up x view with up = n2, view = n1.
      pr_in[0] = $signed(in_n2[1]) * $signed(in_n1[2]);
      pr_in[1] = $signed(in_n2[2]) * $signed(in_n1[1]);
      pr_in[2] = $signed(in_n2[2]) * $signed(in_n1[0]);
      pr_in[3] = $signed(in_n2[0]) * $signed(in_n1[2]);
      pr_in[4] = $signed(in_n2[0]) * $signed(in_n1[1]);
      pr_in[5] = $signed(in_n2[1]) * $signed(in_n1[0]);
      for (int i = 0; i < 3; i++) begin
         c = VW'(pr_ff[2*i]) - VW'(pr_ff[2*i+1]);
         // Drop the extra fraction bits, truncating towards zero.
         m = c[VW-1] ? -c : c;
         m = m >> FRAC_BITS;
         rgt[i] = c[VW-1] ? -m : m;
      end
      up = '0;
      lk = '0;
      for (int i = 0; i < 3; i++) begin
         case (tag_ff.mode)
            bbm_pkg::MODE_SPHERE: begin
               up[i] = VW'($signed(n2_ff[i]));
               lk[i] = VW'($signed(n1_ff[i]));
            end
            bbm_pkg::MODE_UP: begin
               rgt[i] = VW'($signed(n1_ff[i]));
               up[i]  = VW'($signed(tag_ff.ax[i]));
               lk[i]  = VW'($signed(n2_ff[i]));
            end
            default: begin
               rgt[i] = VW'($signed(tag_ff.ax[i]));
               up[i]  = VW'($signed(n1_ff[i]));
               lk[i]  = VW'($signed(n2_ff[i]));
            end
         endcase
      end
      good = (tag_ff.mode != bbm_pkg::MODE_BAD) && ok1_ff && ok2_ff;
      rsp_in.ok = good;
      for (int i = 0; i < 3; i++) begin
         rsp_in.right[i] = good ? bbm_pkg::sat32(rgt[i]) : '0;
         rsp_in.up[i]    = good ? bbm_pkg::sat32(up[i]) : '0;
         rsp_in.look[i]  = good ? bbm_pkg::sat32(lk[i]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ok1_ff <= in_ok1;
         ok2_ff <= in_ok2;
         n1_ff  <= in_n1;
         n2_ff  <= in_n2;
         tag_ff <= in_tag;
         pr_ff  <= pr_in;
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vld2_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

FILE: design/billboard_basis_matrix_unit.sv
// FRAC_BITS sets the fraction bits of the normalised rows (Q16.16 at 16).
// Throughput: one request per cycle; every stage is registered and the
// whole pipeline advances together, held only while a result waits untaken.
// The depth is set by the two normalisers: 31 square root stages and
// FRAC_BITS+1 divider stages each. Synchronous active-high reset empties it.
`default_nettype none

module billboard_basis_matrix_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   bbm_req_if.sink          req_bus,
   bbm_rsp_if.source        rsp_bus
);

   localparam int OW     = FRAC_BITS + 2;
   localparam int TAG_W  = $bits(bbm_pkg::tag_type);
   localparam int SIDE2_W = TAG_W + 3 * OW + 1;

   // The pipeline moves whenever the result register is empty or is being
   // taken this cycle, so a stall freezes every stage in place and nothing
   // is dropped or doubled.
   logic adv;

   logic                              prep_valid;
   logic [2:0][bbm_pkg::VEC_W-1:0]    prep_vec;
   bbm_pkg::tag_type                  prep_tag;

   logic                              n1_valid, n1_ok;
   logic [2:0][OW-1:0]                n1_vec;
   logic [TAG_W-1:0]                  n1_side;

   logic                              mid_valid, mid_ok;
   logic [2:0][bbm_pkg::VEC_W-1:0]    mid_vec;
   bbm_pkg::tag_type                  mid_tag;
   logic [2:0][OW-1:0]                mid_n;

   logic                              n2_valid, n2_ok;
   logic [2:0][OW-1:0]                n2_vec;
   logic [SIDE2_W-1:0]                n2_side;
   bbm_pkg::tag_type                  n2_tag;
   logic [2:0][OW-1:0]                n2_n1;
   logic                              n2_ok1;

   logic                              post_valid;
   bbm_pkg::rsp_type                  post_rsp;

   assign adv           = ~post_valid | rsp_bus.ready;
   // No request is taken while reset holds the valid bits clear.
   assign req_bus.ready = adv & ~reset;

   // Front end: look = eye - obj, pre-shrink of look and axis, and the
   // vector that the first normaliser sees (look itself in spherical mode,
   // the axis/look cross product in the restricted modes).
   bbm_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_bus.valid),
      .in_mode   (bbm_pkg::mode_type'(req_bus.mode)),
      .in_eye    ({req_bus.eye_z, req_bus.eye_y, req_bus.eye_x}),
      .in_obj    ({req_bus.obj_z, req_bus.obj_y, req_bus.obj_x}),
      .in_axis   ({req_bus.axis_z, req_bus.axis_y, req_bus.axis_x}),
      .out_valid (prep_valid),
      .out_vec   (prep_vec),
      .out_tag   (prep_tag)
   );

   // First normalisation: view in spherical mode, right or up otherwise.
   bbm_norm #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (TAG_W)
   ) u_norm1 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (prep_valid),
      .in_vec    (prep_vec),
      .in_side   (prep_tag),
      .out_valid (n1_valid),
      .out_ok    (n1_ok),
      .out_vec   (n1_vec),
      .out_side  (n1_side)
   );

   // Second vector: world up with its view part removed in spherical mode,
   // otherwise the cross product that yields the view row.
   bbm_mid #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mid (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (n1_valid),
      .in_ok     (n1_ok),
      .in_n      (n1_vec),
      .in_tag    (bbm_pkg::tag_type'(n1_side)),
      .out_valid (mid_valid),
      .out_vec   (mid_vec),
      .out_tag   (mid_tag),
      .out_n     (mid_n),
      .out_ok    (mid_ok)
   );

   bbm_norm #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SIDE2_W)
   ) u_norm2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mid_valid),
      .in_vec    (mid_vec),
      .in_side   ({mid_tag, mid_n, mid_ok}),
      .out_valid (n2_valid),
      .out_ok    (n2_ok),
      .out_vec   (n2_vec),
      .out_side  (n2_side)
   );

   assign {n2_tag, n2_n1, n2_ok1} = n2_side;

   // Back end: spherical right = up x view, rows placed per mode, the
   // request cleared to zeros when the mode or either normalisation fails.
   // Its last register is the result register on the response channel.
   bbm_post #(
      .FRAC_BITS (FRAC_BITS)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (n2_valid),
      .in_ok1    (n2_ok1),
      .in_n1     (n2_n1),
      .in_ok2    (n2_ok),
      .in_n2     (n2_vec),
      .in_tag    (n2_tag),
      .out_valid (post_valid),
      .out_rsp   (post_rsp)
   );

   assign rsp_bus.valid   = post_valid;
   assign rsp_bus.ok      = post_rsp.ok;
   assign rsp_bus.right_x = post_rsp.right[0];
   assign rsp_bus.right_y = post_rsp.right[1];
   assign rsp_bus.right_z = post_rsp.right[2];
   assign rsp_bus.up_x    = post_rsp.up[0];
   assign rsp_bus.up_y    = post_rsp.up[1];
   assign rsp_bus.up_z    = post_rsp.up[2];
   assign rsp_bus.look_x  = post_rsp.look[0];
   assign rsp_bus.look_y  = post_rsp.look[1];
   assign rsp_bus.look_z  = post_rsp.look[2];

   // A failed basis carries nothing but zeros.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ok |->
         rsp_bus.right_x == 0 && rsp_bus.right_y == 0 && rsp_bus.right_z == 0 &&
         rsp_bus.up_x == 0 && rsp_bus.up_y == 0 && rsp_bus.up_z == 0 &&
         rsp_bus.look_x == 0 && rsp_bus.look_y == 0 && rsp_bus.look_z == 0)
      else $error("failed basis with non-zero rows");

   // A good basis always has a normalised, hence non-zero, view row.
   a_look_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ok |->
         rsp_bus.look_x != 0 || rsp_bus.look_y != 0 || rsp_bus.look_z != 0)
      else $error("good basis with a zero view row");

   // Reset empties the pipeline, so no result may follow it directly.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result present straight after reset");

endmodule

`default_nettype wire
